// ----- sv/kf3_pkg.sv -----
// Shared types, constants and helpers of the three-state Kalman filter core.
package kf3_pkg;

    localparam int unsigned STATE_DIM = 3;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned DAT_W     = 32;
    localparam int unsigned COV_W     = 48;
    localparam int unsigned NUM_CFG   = 7;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_POS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_VEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_ACC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_POS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VEL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ACC   = 3'd6;

    localparam logic [DAT_W-1:0] RST_MEAS_NOISE = 32'd65536000;
    localparam logic [DAT_W-1:0] RST_PROC_POS   = 32'd65536;
    localparam logic [DAT_W-1:0] RST_PROC_VEL   = 32'd655;
    localparam logic [DAT_W-1:0] RST_PROC_ACC   = 32'd655;
    localparam logic [DAT_W-1:0] RST_INIT_POS   = 32'd655360;
    localparam logic [DAT_W-1:0] RST_INIT_VEL   = 32'd655360;
    localparam logic [DAT_W-1:0] RST_INIT_ACC   = 32'd65536;

    localparam logic ACTION_INIT = 1'b0;
    localparam logic ACTION_MEAS = 1'b1;

    typedef struct packed {
        logic                    action;
        logic signed [DAT_W-1:0] measurement;
        logic signed [DAT_W-1:0] start_pos;
        logic signed [DAT_W-1:0] start_vel;
        logic signed [DAT_W-1:0] start_acc;
    } t_in_item;

    typedef struct packed {
        logic signed [DAT_W-1:0] est_pos;
        logic signed [DAT_W-1:0] est_vel;
        logic signed [DAT_W-1:0] est_acc;
        logic signed [DAT_W-1:0] gain_pos;
        logic signed [DAT_W-1:0] gain_vel;
        logic signed [DAT_W-1:0] gain_acc;
        logic                    div_fault;
    } t_out_item;

    typedef struct packed {
        logic                    start;
        logic signed [COV_W-1:0] num;
        logic signed [COV_W:0]   den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [DAT_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_WR,
        ST_FETCH_RD,
        ST_FETCH_CAP,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_XUPD,
        ST_UPD_RD,
        ST_UPD_CAP,
        ST_UPD_WR,
        ST_EMIT
    } t_state;

    function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [COV_W+3:0] v);
        logic signed [COV_W-1:0] res;
        if (v[COV_W+3:COV_W-1] == '0 || v[COV_W+3:COV_W-1] == '1) begin
            res = v[COV_W-1:0];
        end else if (v[COV_W+3]) begin
            res = {1'b1, {(COV_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COV_W-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [DAT_W-1:0] sat_dat(input logic signed [2*DAT_W+1:0] v);
        logic signed [DAT_W-1:0] res;
        if (v[2*DAT_W+1:DAT_W-1] == '0 || v[2*DAT_W+1:DAT_W-1] == '1) begin
            res = v[DAT_W-1:0];
        end else if (v[2*DAT_W+1]) begin
            res = {1'b1, {(DAT_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DAT_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ----- sv/kf3_div.sv -----
// Serial restoring divider for the gain: (num << FRAC_BITS) / den, saturated to 32 bits.
module kf3_div #(
    parameter int unsigned FRAC_BITS = kf3_pkg::FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kf3_pkg::t_div_req i_req,
    output kf3_pkg::t_div_rsp o_rsp
);

    localparam int unsigned CW  = kf3_pkg::COV_W;
    localparam int unsigned DW  = kf3_pkg::DAT_W;
    localparam int unsigned NW  = CW + FRAC_BITS;
    localparam int unsigned CNW = $clog2(NW);
    localparam logic [CNW-1:0] LAST = CNW'(NW - 1);

    logic            r_busy;
    logic            r_done;
    logic [CNW-1:0]  r_cnt;
    logic [NW-1:0]   r_dvd;
    logic [NW-1:0]   r_quo;
    logic [CW:0]     r_rem;
    logic [CW:0]     r_den;
    logic            r_neg;
    logic signed [DW-1:0] r_quot;

    logic [CW+1:0]   rem_sh;
    logic            q_bit;
    logic [CW:0]     rem_nx;
    logic [NW-1:0]   q_fin;
    logic [NW-1:0]   q_lim;
    logic [DW-1:0]   q_sat;
    logic [CW-1:0]   num_mag;
    logic [CW:0]     den_mag;

    always_comb begin
        num_mag = i_req.num[CW-1] ? CW'(-i_req.num) : CW'(i_req.num);
        den_mag = i_req.den[CW] ? (CW+1)'(-i_req.den) : (CW+1)'(i_req.den);
        rem_sh  = {r_rem, r_dvd[NW-1]};
        q_bit   = rem_sh >= {1'b0, r_den};
        rem_nx  = q_bit ? (CW+1)'(rem_sh - {1'b0, r_den}) : rem_sh[CW:0];
        q_fin   = {r_quo[NW-2:0], q_bit};
        q_lim   = r_neg ? NW'({1'b1, {(DW-1){1'b0}}}) : NW'({1'b0, {(DW-1){1'b1}}});
        q_sat   = (q_fin > q_lim) ? q_lim[DW-1:0] : q_fin[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= {num_mag, {FRAC_BITS{1'b0}}};
            r_den <= den_mag;
            r_neg <= i_req.num[CW-1] ^ i_req.den[CW];
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[NW-2:0], 1'b0};
            r_rem <= rem_nx;
            r_quo <= q_fin;
            if (r_cnt == LAST) begin
                r_quot <= r_neg ? DW'(-q_sat) : q_sat;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- sv/kalman_filter_3state_scalar_meas_core.sv -----
// Three-state Kalman filter core: covariance memory, sequencer and fixed point datapath.
// One item at a time. An init item writes every covariance entry, one write per cycle. A
// measure item computes its gains with the serial gain divider, one quotient bit per cycle
// and shared by all gains. The covariance sits in a synchronous RAM with separate read and
// write addresses and registered read data; per-entry valid bits cleared at reset make
// unwritten entries read as the reset diagonal, so no clearing pass is needed.
// A finished item waits in the output register while the next item is taken.
module kalman_filter_3state_scalar_meas_core #(
    parameter int unsigned STATE_DIM = kf3_pkg::STATE_DIM,
    parameter int unsigned FRAC_BITS = kf3_pkg::FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  kf3_pkg::t_in_item                i_in_item,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output kf3_pkg::t_out_item               o_out_item,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_we,
    input  logic [kf3_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kf3_pkg::DAT_W-1:0]        i_cfg_data
);

    localparam int unsigned DW = kf3_pkg::DAT_W;
    localparam int unsigned CW = kf3_pkg::COV_W;
    localparam int unsigned NE = STATE_DIM * STATE_DIM;
    localparam int unsigned AW = (NE > 1) ? $clog2(NE) : 1;
    localparam int unsigned IW = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
    localparam int unsigned FW = $clog2(2 * STATE_DIM);
    localparam int unsigned HW = CW / 2;
    localparam int unsigned PW = 2 * CW - HW + DW;
    localparam logic [IW-1:0] ILAST = IW'(STATE_DIM - 1);
    localparam logic [FW-1:0] FLAST = FW'(2 * STATE_DIM - 2);
    localparam logic [FW-1:0] FDIM  = FW'(STATE_DIM);
    localparam logic [AW-1:0] ADIM  = AW'(STATE_DIM);

    kf3_pkg::t_state n_state, r_state;

    logic [DW-1:0]           r_cfg [kf3_pkg::NUM_CFG];
    logic signed [DW-1:0]    r_x   [STATE_DIM];
    logic signed [DW-1:0]    r_g   [STATE_DIM];
    logic signed [CW-1:0]    r_col [STATE_DIM];
    logic signed [CW-1:0]    r_row [STATE_DIM];
    logic signed [DW-1:0]    r_meas;
    logic signed [DW:0]      r_innov;
    logic signed [CW:0]      r_s;
    logic                    r_fault;
    logic [IW-1:0]           r_i, r_j, r_k;
    logic [FW-1:0]           r_f;
    logic [DW+HW-1:0]        r_plo;
    logic [DW+HW-1:0]        r_phi;
    logic signed [CW-1:0]    r_pp;

    logic [CW-1:0]           r_cov_mem [NE];
    logic [NE-1:0]           r_cov_vld;
    logic [CW-1:0]           r_mem_q;
    logic                    r_rd_vld;
    logic signed [CW-1:0]    r_rd_def;

    logic                    r_out_valid;
    kf3_pkg::t_out_item      r_out_item;

    logic                    mem_re, mem_we;
    logic [AW-1:0]           mem_raddr, mem_waddr;
    logic signed [CW-1:0]    mem_wdata, mem_rdef, mem_rdata;
    kf3_pkg::t_div_req       div_req;
    kf3_pkg::t_div_rsp       div_rsp;

    logic                    in_acc, out_free;
    logic                    f_is_col;
    logic [IW-1:0]           f_idx;
    logic signed [CW:0]      s_sum;
    logic signed [CW-1:0]    pp_cur;
    logic [DW-1:0]           g_mag_i, g_mag_k;
    logic [CW-1:0]           row_mag;
    logic                    upd_neg;
    logic [PW-1:0]           upd_prod;
    logic [PW-1:0]           upd_sm;
    logic [CW+1:0]           upd_cap;
    logic signed [CW+3:0]    upd_x;
    logic signed [CW-1:0]    upd_val;
    logic [DW:0]             inn_mag;
    logic [2*DW:0]           x_prod;
    logic [2*DW:0]           x_sm;
    logic signed [2*DW+1:0]  x_val;
    logic signed [DW-1:0]    x_new;
    logic signed [DW-1:0]    est_arr  [3];
    logic signed [DW-1:0]    gain_arr [3];
    logic signed [DW-1:0]    start_arr [3];

    function automatic logic [DW-1:0] q_of(input logic [IW-1:0] i, input logic [DW-1:0] qp,
                                           input logic [DW-1:0] qv, input logic [DW-1:0] qa);
        logic [DW-1:0] res;
        if (i == 0)      res = qp;
        else if (i == 1) res = qv;
        else if (i == 2) res = qa;
        else             res = '0;
        return res;
    endfunction

    function automatic logic [IW+AW-1:0] addr_of(input logic [IW-1:0] i, input logic [IW-1:0] j);
        return (IW+AW)'(i) * (IW+AW)'(ADIM) + (IW+AW)'(j);
    endfunction

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign start_arr[0] = i_in_item.start_pos;
    assign start_arr[1] = i_in_item.start_vel;
    assign start_arr[2] = i_in_item.start_acc;

    genvar gk;
    generate
        for (gk = 0; gk < 3; gk++) begin : g_out
            if (gk < STATE_DIM) begin : g_on
                assign est_arr[gk]  = r_x[gk];
                assign gain_arr[gk] = r_g[gk];
            end else begin : g_off
                assign est_arr[gk]  = '0;
                assign gain_arr[gk] = '0;
            end
        end
    endgenerate

    // read data of the covariance RAM; entries never written read as the reset diagonal
    assign mem_rdata = r_rd_vld ? $signed(r_mem_q) : r_rd_def;

    always_comb begin
        f_is_col = r_f < FDIM;
        f_idx    = f_is_col ? IW'(r_f) : IW'(r_f - FDIM + 1'b1);
        s_sum    = (CW+1)'(r_col[0]) + $signed({1'b0, r_cfg[kf3_pkg::CFG_MEAS_NOISE]});

        pp_cur = mem_rdata;
        if (r_i == r_j) begin
            pp_cur = kf3_pkg::sat_cov((CW+4)'(mem_rdata) + $signed({4'b0,
                     q_of(r_i, r_cfg[kf3_pkg::CFG_PROC_POS], r_cfg[kf3_pkg::CFG_PROC_VEL],
                          r_cfg[kf3_pkg::CFG_PROC_ACC])}));
        end

        g_mag_i  = r_g[r_i][DW-1] ? DW'(-r_g[r_i]) : DW'(r_g[r_i]);
        row_mag  = r_row[r_j][CW-1] ? CW'(-r_row[r_j]) : CW'(r_row[r_j]);
        upd_neg  = r_g[r_i][DW-1] ^ r_row[r_j][CW-1];
        upd_prod = PW'(r_plo) + (PW'(r_phi) << HW);
        upd_sm   = upd_prod >> FRAC_BITS;
        upd_cap  = (upd_sm >= (PW'(1) << (CW + 2))) ? '1 : upd_sm[CW+1:0];
        upd_x    = upd_neg ? -$signed({2'b0, upd_cap}) : $signed({2'b0, upd_cap});
        upd_val  = kf3_pkg::sat_cov((CW+4)'(r_pp) - upd_x);

        g_mag_k  = r_g[r_k][DW-1] ? DW'(-r_g[r_k]) : DW'(r_g[r_k]);
        inn_mag  = r_innov[DW] ? (DW+1)'(-r_innov) : (DW+1)'(r_innov);
        x_prod   = (2*DW+1)'(g_mag_k) * (2*DW+1)'(inn_mag);
        x_sm     = x_prod >> FRAC_BITS;
        x_val    = (r_g[r_k][DW-1] ^ r_innov[DW]) ? -$signed({1'b0, x_sm})
                                                   : $signed({1'b0, x_sm});
        x_new    = kf3_pkg::sat_dat((2*DW+2)'(r_x[r_k]) + x_val);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kf3_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_item.action == kf3_pkg::ACTION_INIT) ? kf3_pkg::ST_INIT_WR
                                                                        : kf3_pkg::ST_FETCH_RD;
                end
            end
            kf3_pkg::ST_INIT_WR: begin
                if (r_i == ILAST && r_j == ILAST) n_state = kf3_pkg::ST_EMIT;
            end
            kf3_pkg::ST_FETCH_RD:  n_state = kf3_pkg::ST_FETCH_CAP;
            kf3_pkg::ST_FETCH_CAP: begin
                n_state = (r_f == FLAST) ? kf3_pkg::ST_SUM : kf3_pkg::ST_FETCH_RD;
            end
            kf3_pkg::ST_SUM: begin
                n_state = (s_sum == '0) ? kf3_pkg::ST_EMIT : kf3_pkg::ST_DIV_GO;
            end
            kf3_pkg::ST_DIV_GO:   n_state = kf3_pkg::ST_DIV_WAIT;
            kf3_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_k == ILAST) ? kf3_pkg::ST_XUPD : kf3_pkg::ST_DIV_GO;
                end
            end
            kf3_pkg::ST_XUPD: begin
                if (r_k == ILAST) n_state = kf3_pkg::ST_UPD_RD;
            end
            kf3_pkg::ST_UPD_RD:  n_state = kf3_pkg::ST_UPD_CAP;
            kf3_pkg::ST_UPD_CAP: n_state = kf3_pkg::ST_UPD_WR;
            kf3_pkg::ST_UPD_WR: begin
                n_state = (r_i == '0 && r_j == ILAST) ? kf3_pkg::ST_EMIT : kf3_pkg::ST_UPD_RD;
            end
            kf3_pkg::ST_EMIT: begin
                if (out_free) n_state = kf3_pkg::ST_IDLE;
            end
            default: n_state = kf3_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall    = 1'b1;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        mem_rdef      = '0;
        mem_we        = 1'b0;
        mem_waddr     = AW'(addr_of(r_i, r_j));
        mem_wdata     = '0;
        div_req.start = 1'b0;
        div_req.num   = r_col[r_k];
        div_req.den   = r_s;
        case (r_state)
            kf3_pkg::ST_IDLE: o_in_stall = 1'b0;
            kf3_pkg::ST_INIT_WR: begin
                mem_we = 1'b1;
                if (r_i == r_j) begin
                    mem_wdata = CW'(q_of(r_i, r_cfg[kf3_pkg::CFG_INIT_POS],
                                         r_cfg[kf3_pkg::CFG_INIT_VEL],
                                         r_cfg[kf3_pkg::CFG_INIT_ACC]));
                end
            end
            kf3_pkg::ST_FETCH_RD: begin
                mem_re    = 1'b1;
                mem_raddr = f_is_col ? AW'(addr_of(f_idx, '0)) : AW'(f_idx);
                if (f_is_col && f_idx == '0) mem_rdef = CW'(kf3_pkg::RST_INIT_POS);
            end
            kf3_pkg::ST_DIV_GO: div_req.start = 1'b1;
            kf3_pkg::ST_UPD_RD: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(addr_of(r_i, r_j));
                if (r_i == r_j) begin
                    mem_rdef = CW'(q_of(r_i, kf3_pkg::RST_INIT_POS, kf3_pkg::RST_INIT_VEL,
                                        kf3_pkg::RST_INIT_ACC));
                end
            end
            kf3_pkg::ST_UPD_WR: begin
                mem_we    = 1'b1;
                mem_wdata = upd_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kf3_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[kf3_pkg::CFG_MEAS_NOISE] <= kf3_pkg::RST_MEAS_NOISE;
            r_cfg[kf3_pkg::CFG_PROC_POS]   <= kf3_pkg::RST_PROC_POS;
            r_cfg[kf3_pkg::CFG_PROC_VEL]   <= kf3_pkg::RST_PROC_VEL;
            r_cfg[kf3_pkg::CFG_PROC_ACC]   <= kf3_pkg::RST_PROC_ACC;
            r_cfg[kf3_pkg::CFG_INIT_POS]   <= kf3_pkg::RST_INIT_POS;
            r_cfg[kf3_pkg::CFG_INIT_VEL]   <= kf3_pkg::RST_INIT_VEL;
            r_cfg[kf3_pkg::CFG_INIT_ACC]   <= kf3_pkg::RST_INIT_ACC;
        end else if (i_cfg_we && i_cfg_idx <= kf3_pkg::CFG_INIT_ACC) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // covariance RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) r_cov_mem[mem_waddr] <= mem_wdata;
        if (mem_re) begin
            r_mem_q  <= r_cov_mem[mem_raddr];
            r_rd_def <= mem_rdef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cov_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) r_cov_vld[mem_waddr] <= 1'b1;
            if (mem_re) r_rd_vld <= r_cov_vld[mem_raddr];
        end
    end

    // state vector, state machine counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STATE_DIM; k++) r_x[k] <= '0;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
            r_f <= '0;
        end else begin
            case (r_state)
                kf3_pkg::ST_IDLE: begin
                    r_i <= '0;
                    r_j <= '0;
                    r_f <= '0;
                    if (in_acc && i_in_item.action == kf3_pkg::ACTION_INIT) begin
                        for (int k = 0; k < STATE_DIM; k++) begin
                            r_x[k] <= (k < 3) ? start_arr[k] : '0;
                        end
                    end
                end
                kf3_pkg::ST_INIT_WR: begin
                    if (r_j == ILAST) begin
                        r_j <= '0;
                        r_i <= (r_i == ILAST) ? '0 : r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                kf3_pkg::ST_FETCH_CAP: r_f <= r_f + 1'b1;
                kf3_pkg::ST_SUM:       r_k <= '0;
                kf3_pkg::ST_DIV_WAIT: begin
                    if (div_rsp.done) r_k <= (r_k == ILAST) ? '0 : r_k + 1'b1;
                end
                kf3_pkg::ST_XUPD: begin
                    r_x[r_k] <= x_new;
                    r_k      <= (r_k == ILAST) ? '0 : r_k + 1'b1;
                    r_i      <= ILAST;
                    r_j      <= '0;
                end
                kf3_pkg::ST_UPD_WR: begin
                    if (r_j == ILAST) begin
                        r_j <= '0;
                        if (r_i != '0) r_i <= r_i - 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            kf3_pkg::ST_IDLE: begin
                if (in_acc) begin
                    for (int k = 0; k < STATE_DIM; k++) r_g[k] <= '0;
                    r_fault <= 1'b0;
                    r_meas  <= i_in_item.measurement;
                end
            end
            kf3_pkg::ST_FETCH_CAP: begin
                if (f_is_col) begin
                    if (f_idx == '0) begin
                        r_col[0] <= kf3_pkg::sat_cov((CW+4)'(mem_rdata)
                                    + $signed({4'b0, r_cfg[kf3_pkg::CFG_PROC_POS]}));
                        r_row[0] <= kf3_pkg::sat_cov((CW+4)'(mem_rdata)
                                    + $signed({4'b0, r_cfg[kf3_pkg::CFG_PROC_POS]}));
                    end else begin
                        r_col[f_idx] <= mem_rdata;
                    end
                end else begin
                    r_row[f_idx] <= mem_rdata;
                end
            end
            kf3_pkg::ST_SUM: begin
                r_s     <= s_sum;
                r_innov <= (DW+1)'(r_meas) - (DW+1)'(r_x[0]);
                r_fault <= (s_sum == '0);
            end
            kf3_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) r_g[r_k] <= div_rsp.quot;
            end
            kf3_pkg::ST_UPD_RD: begin
                r_plo <= (DW+HW)'(g_mag_i) * (DW+HW)'(row_mag[HW-1:0]);
            end
            kf3_pkg::ST_UPD_CAP: begin
                r_phi <= (DW+HW)'(g_mag_i) * (DW+HW)'(row_mag[CW-1:HW]);
                r_pp  <= pp_cur;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == kf3_pkg::ST_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kf3_pkg::ST_EMIT && out_free) begin
            r_out_item.est_pos   <= est_arr[0];
            r_out_item.est_vel   <= est_arr[1];
            r_out_item.est_acc   <= est_arr[2];
            r_out_item.gain_pos  <= gain_arr[0];
            r_out_item.gain_vel  <= gain_arr[1];
            r_out_item.gain_acc  <= gain_arr[2];
            r_out_item.div_fault <= r_fault;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    kf3_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

// ----- sv/kf3_chk.sv -----
// Port-level checker for the Kalman filter core, bound to the top level.
module kf3_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input kf3_pkg::t_out_item o_out_item,
    input logic               i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    a_fault_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.div_fault |->
            o_out_item.gain_pos == '0 && o_out_item.gain_vel == '0 &&
            o_out_item.gain_acc == '0)
        else $error("nonzero gain on fault");

    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result shown while still busy");

endmodule

bind kalman_filter_3state_scalar_meas_core kf3_chk u_kf3_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);
